>>> hw/rtl/object_name_validator_assert.svh
// Assertion macros shared by the object name validator RTL.
// Each macro expects clk and rst_n in scope.
`ifndef OBJECT_NAME_VALIDATOR_ASSERT_SVH
`define OBJECT_NAME_VALIDATOR_ASSERT_SVH

// Same-cycle implication.
`define ONV_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ONV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold at every edge.
`define ONV_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

>>> hw/rtl/onv_pkg.sv
`default_nettype none

package onv_pkg;

    localparam int unsigned PREFIX_LEN = 26;
    localparam int unsigned POS_W      = 5;

    // Range allowed for the next continuation byte
    typedef enum logic [2:0] {
        BND_80_BF = 3'd0,
        BND_A0_BF = 3'd1,
        BND_80_9F = 3'd2,
        BND_90_BF = 3'd3,
        BND_80_8F = 3'd4
    } bound_t;

    typedef struct packed {
        logic [1:0] pending;
        bound_t     bound;
    } utf8_state_t;

    localparam utf8_state_t UTF8_IDLE = '{pending: 2'd0, bound: BND_80_BF};

    // Reserved prefix ".well-known/acme-challenge", one character per position
    function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            5'd0:    c = ".";
            5'd1:    c = "w";
            5'd2:    c = "e";
            5'd3:    c = "l";
            5'd4:    c = "l";
            5'd5:    c = "-";
            5'd6:    c = "k";
            5'd7:    c = "n";
            5'd8:    c = "o";
            5'd9:    c = "w";
            5'd10:   c = "n";
            5'd11:   c = "/";
            5'd12:   c = "a";
            5'd13:   c = "c";
            5'd14:   c = "m";
            5'd15:   c = "e";
            5'd16:   c = "-";
            5'd17:   c = "c";
            5'd18:   c = "h";
            5'd19:   c = "a";
            5'd20:   c = "l";
            5'd21:   c = "l";
            5'd22:   c = "e";
            5'd23:   c = "n";
            5'd24:   c = "g";
            5'd25:   c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/onv_utf8_step.sv
`default_nettype none

// One byte of the RFC 3629 decoder: next sequence state and error flag.
module onv_utf8_step (
    input  wire logic [7:0]          data_byte,
    input  wire onv_pkg::utf8_state_t state_cur,
    output onv_pkg::utf8_state_t     state_nxt,
    output logic                     bad
);

    logic in_range;

    always_comb
    begin
        unique case (state_cur.bound)
            onv_pkg::BND_A0_BF: in_range = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
            onv_pkg::BND_80_9F: in_range = (data_byte >= 8'h80) && (data_byte <= 8'h9F);
            onv_pkg::BND_90_BF: in_range = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
            onv_pkg::BND_80_8F: in_range = (data_byte >= 8'h80) && (data_byte <= 8'h8F);
            default:            in_range = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
        endcase
    end

    always_comb
    begin
        state_nxt = onv_pkg::UTF8_IDLE;
        bad       = 1'b0;
        if (state_cur.pending != 2'd0)
        begin
            // inside a sequence: consume or drop it
            if (in_range)
                state_nxt.pending = state_cur.pending - 2'd1;
            else
                bad = 1'b1;
        end
        else
        begin
            case (data_byte) inside
                [8'h00:8'h7F]: ;
                [8'hC2:8'hDF]: state_nxt.pending = 2'd1;
                8'hE0:
                begin
                    state_nxt.pending = 2'd2;
                    state_nxt.bound   = onv_pkg::BND_A0_BF;
                end
                8'hED:
                begin
                    state_nxt.pending = 2'd2;
                    state_nxt.bound   = onv_pkg::BND_80_9F;
                end
                [8'hE1:8'hEF]: state_nxt.pending = 2'd2;
                8'hF0:
                begin
                    state_nxt.pending = 2'd3;
                    state_nxt.bound   = onv_pkg::BND_90_BF;
                end
                [8'hF1:8'hF3]: state_nxt.pending = 2'd3;
                8'hF4:
                begin
                    state_nxt.pending = 2'd3;
                    state_nxt.bound   = onv_pkg::BND_80_8F;
                end
                default: bad = 1'b1;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/object_name_validator.sv
// Object name validator.
// Input stream: one word per name byte. s_axis_tdata carries the byte,
// s_axis_tlast marks the last byte of a name, and s_axis_tuser marks a word
// that carries no byte and ends the name at once (an empty name, or an
// early cut of a name in progress).
// Output stream: one word per completed name; m_axis_tdata[0] is 1 when
// the name is a valid object name (non-empty, at most MAX_NAME_BYTES bytes,
// not "." or "..", no reserved ".well-known/acme-challenge" prefix, no
// control bytes, well-formed UTF-8).
// The verdict shows on m_axis_tvalid in the cycle after the word that
// ends the name is taken. One word is taken per clock while s_axis_tready
// is high; the per-byte checks are a byte compare, an 11-bit increment
// and a small UTF-8 decode between the name state and output registers.
// Reset clears all name state and drops any pending verdict.
// When the receiver stalls, the verdict holds in the output register and
// the input stays open only if that register is free or being drained in
// the same cycle.
`default_nettype none

module object_name_validator #(
    parameter int unsigned MAX_NAME_BYTES = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] name_byte
    input  wire logic       s_axis_tlast,   // end_of_name
    input  wire logic       s_axis_tuser,   // empty_name
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] name_valid, [7:1] zero
);

    `include "object_name_validator_assert.svh"

    // Count saturates one past the limit, so it must hold MAX_NAME_BYTES + 1
    localparam int unsigned CNT_W = $clog2(MAX_NAME_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(MAX_NAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_NAME_BYTES);
    localparam logic [onv_pkg::POS_W-1:0] POS_END = onv_pkg::POS_W'(onv_pkg::PREFIX_LEN);

    // Name state
    logic [CNT_W-1:0]          cnt_reg,   cnt_next;
    logic [onv_pkg::POS_W-1:0] pos_reg,   pos_next;
    logic                      match_reg, match_next;
    logic                      dots_reg,  dots_next;
    logic                      bad_reg,   bad_next;
    onv_pkg::utf8_state_t      utf8_reg,  utf8_next;

    // Output register
    logic m_valid_reg;
    logic m_data_reg;

    logic                 accept;
    logic                 name_done;
    logic                 ctrl_byte;
    logic                 utf8_bad;
    onv_pkg::utf8_state_t utf8_step;

    // Values the verdict is taken from
    logic [CNT_W-1:0]          j_cnt;
    logic [onv_pkg::POS_W-1:0] j_pos;
    logic                      j_match;
    logic                      j_dots;
    logic                      j_bad;
    logic [1:0]                j_pending;
    logic                      verdict;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign name_done     = s_axis_tuser || s_axis_tlast;

    onv_utf8_step u_utf8 (
        .data_byte (s_axis_tdata),
        .state_cur (utf8_reg),
        .state_nxt (utf8_step),
        .bad       (utf8_bad)
    );

    // Fold the byte into the name state
    always_comb
    begin
        ctrl_byte  = (s_axis_tdata <= 8'h1F) || (s_axis_tdata == 8'h7F);
        cnt_next   = (cnt_reg < CNT_SAT) ? cnt_reg + CNT_W'(1) : cnt_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        if (match_reg && (pos_reg < POS_END))
        begin
            if (s_axis_tdata == onv_pkg::prefix_char(pos_reg))
                pos_next = pos_reg + onv_pkg::POS_W'(1);
            else
                match_next = 1'b0;
        end
        dots_next = dots_reg && (s_axis_tdata == 8'h2E);
        bad_next  = bad_reg || ctrl_byte || utf8_bad;
        utf8_next = utf8_step;
    end

    // An empty-name word judges the name as it stands, without a byte
    always_comb
    begin
        if (s_axis_tuser)
        begin
            j_cnt     = cnt_reg;
            j_pos     = pos_reg;
            j_match   = match_reg;
            j_dots    = dots_reg;
            j_bad     = bad_reg;
            j_pending = utf8_reg.pending;
        end
        else
        begin
            j_cnt     = cnt_next;
            j_pos     = pos_next;
            j_match   = match_next;
            j_dots    = dots_next;
            j_bad     = bad_next;
            j_pending = utf8_next.pending;
        end
        verdict = (j_cnt != '0) && (j_cnt <= CNT_LIMIT)
               && !(j_dots && (j_cnt <= CNT_W'(2)))
               && !(j_match && (j_pos == POS_END))
               && !j_bad && (j_pending == 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            pos_reg   <= '0;
            match_reg <= 1'b1;
            dots_reg  <= 1'b1;
            bad_reg   <= 1'b0;
            utf8_reg  <= onv_pkg::UTF8_IDLE;
        end
        else if (accept)
        begin
            if (name_done)
            begin
                // start the next name from scratch
                cnt_reg   <= '0;
                pos_reg   <= '0;
                match_reg <= 1'b1;
                dots_reg  <= 1'b1;
                bad_reg   <= 1'b0;
                utf8_reg  <= onv_pkg::UTF8_IDLE;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                pos_reg   <= pos_next;
                match_reg <= match_next;
                dots_reg  <= dots_next;
                bad_reg   <= bad_next;
                utf8_reg  <= utf8_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (accept && name_done)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    // Payload: load with each verdict, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept && name_done)
            m_data_reg <= verdict;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_data_reg};

    `ONV_ASSERT_NEXT(a_verdict_out, accept && name_done, m_axis_tvalid,
        "ending word did not produce a verdict")
    `ONV_ASSERT_IMPLY(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "input taken while verdict is stalled")
    `ONV_ASSERT_ALWAYS(a_count_saturates, cnt_reg <= CNT_SAT,
        "byte count ran past saturation")
    `ONV_ASSERT_IMPLY(a_bound_in_sequence, utf8_reg.bound != onv_pkg::BND_80_BF,
        utf8_reg.pending == 2'd2 || utf8_reg.pending == 2'd3,
        "narrow continuation range outside a multibyte lead")

endmodule

`default_nettype wire

>>> verif/object_name_validator_test.sv
`timescale 1ns / 100ps

// Testbench for the object name validator. Names go in as a word stream,
// one byte per word. A predictor follows each accepted word and queues the
// verdict it expects when a name ends. The monitor checks every verdict
// word against the oldest queued one.
module object_name_validator_test;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned NAME_LIMIT   = 1024;
    localparam int unsigned RANDOM_WORDS = 1250;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    localparam logic [7:0] DOT = 8'h2E;
    // Reserved prefix, first character in the top byte
    localparam logic [8*onv_pkg::PREFIX_LEN-1:0] RESERVED_PREFIX = ".well-known/acme-challenge";

    typedef struct {
        logic [7:0] name_byte;
        logic       end_of_name;
        logic       empty_name;
    } name_word_t;

    // Clock, reset and every block input start at a known value
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] name_byte
    logic       s_axis_tlast  = 1'b0;    // end_of_name
    logic       s_axis_tuser  = 1'b0;    // empty_name
    logic       m_axis_tready = 1'b0;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;            // [0] name_valid, [7:1] zero

    object_name_validator #(
        .MAX_NAME_BYTES(NAME_LIMIT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    name_word_t  name_words[$];        // words waiting to be offered
    logic        pending_verdicts[$];  // verdicts predicted, not yet seen
    logic [7:0]  name_buf[$];          // bytes of the name being built
    int unsigned fault_count  = 0;
    int unsigned random_words = 0;

    // ------------------------------------------------------------------
    // Predictor: shadow copy of the per-name state
    // ------------------------------------------------------------------
    logic [10:0]      seen_bytes   = '0;
    logic [4:0]       prefix_pos   = '0;
    logic             prefix_alive = 1'b1;
    logic             all_dots     = 1'b1;
    logic             saw_bad      = 1'b0;
    logic [1:0]       owed_cont    = '0;
    onv_pkg::bound_t  cont_bound   = onv_pkg::BND_80_BF;

    function automatic logic bound_admits(logic [7:0] b, onv_pkg::bound_t bnd);
        case (bnd)
            onv_pkg::BND_A0_BF: return b >= 8'hA0 && b <= 8'hBF;
            onv_pkg::BND_80_9F: return b >= 8'h80 && b <= 8'h9F;
            onv_pkg::BND_90_BF: return b >= 8'h90 && b <= 8'hBF;
            onv_pkg::BND_80_8F: return b >= 8'h80 && b <= 8'h8F;
            default:            return b >= 8'h80 && b <= 8'hBF;
        endcase
    endfunction

    task automatic clear_name_state();
        seen_bytes   = '0;
        prefix_pos   = '0;
        prefix_alive = 1'b1;
        all_dots     = 1'b1;
        saw_bad      = 1'b0;
        owed_cont    = '0;
        cont_bound   = onv_pkg::BND_80_BF;
    endtask

    task automatic absorb_byte(logic [7:0] b);
        if (seen_bytes < NAME_LIMIT + 1)
            seen_bytes++;
        if (prefix_alive && prefix_pos < onv_pkg::PREFIX_LEN)
        begin
            if (b == RESERVED_PREFIX[8 * (onv_pkg::PREFIX_LEN - 1 - prefix_pos) +: 8])
                prefix_pos++;
            else
                prefix_alive = 1'b0;
        end
        if (b != DOT)
            all_dots = 1'b0;
        if (b <= 8'h1F || b == 8'h7F)
            saw_bad = 1'b1;
        if (owed_cont != 0)
        begin
            // Continuation byte expected: a miss drops the sequence
            if (bound_admits(b, cont_bound))
                owed_cont--;
            else
            begin
                saw_bad   = 1'b1;
                owed_cont = '0;
            end
            cont_bound = onv_pkg::BND_80_BF;
        end
        else
        begin
            cont_bound = onv_pkg::BND_80_BF;
            if (b >= 8'hC2 && b <= 8'hDF)
                owed_cont = 2'd1;
            else if (b == 8'hE0)
            begin
                owed_cont  = 2'd2;
                cont_bound = onv_pkg::BND_A0_BF;   // reject overlong three-byte forms
            end
            else if (b == 8'hED)
            begin
                owed_cont  = 2'd2;
                cont_bound = onv_pkg::BND_80_9F;   // reject surrogates
            end
            else if (b >= 8'hE1 && b <= 8'hEF)
                owed_cont = 2'd2;
            else if (b == 8'hF0)
            begin
                owed_cont  = 2'd3;
                cont_bound = onv_pkg::BND_90_BF;   // reject overlong four-byte forms
            end
            else if (b >= 8'hF1 && b <= 8'hF3)
                owed_cont = 2'd3;
            else if (b == 8'hF4)
            begin
                owed_cont  = 2'd3;
                cont_bound = onv_pkg::BND_80_8F;   // stop at U+10FFFF
            end
            else if (b >= 8'h80)
                saw_bad = 1'b1;           // stray continuation or bad lead
        end
    endtask

    function automatic logic name_verdict();
        if (seen_bytes == 0 || seen_bytes > NAME_LIMIT)
            return 1'b0;
        if (all_dots && seen_bytes <= 2)
            return 1'b0;
        if (prefix_alive && prefix_pos == onv_pkg::PREFIX_LEN)
            return 1'b0;
        if (saw_bad || owed_cont != 0)
            return 1'b0;
        return 1'b1;
    endfunction

    // An empty word ends the name whatever its end flag says
    task automatic predict_verdict(name_word_t w);
        if (!w.empty_name)
            absorb_byte(w.name_byte);
        if (w.empty_name || w.end_of_name)
        begin
            pending_verdicts.push_back(name_verdict());
            clear_name_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Name builders
    // ------------------------------------------------------------------

    // Turn the bytes in name_buf into words; a cut name ends on an empty word
    task automatic queue_name(bit cut_early, bit counted);
        name_word_t w;
        int unsigned n;
        n = name_buf.size();
        foreach (name_buf[i])
        begin
            w.name_byte   = name_buf[i];
            w.end_of_name = !cut_early && (i == n - 1);
            w.empty_name  = 1'b0;
            name_words.push_back(w);
        end
        if (cut_early || n == 0)
        begin
            w.name_byte   = 8'($urandom_range(0, 255));
            w.end_of_name = 1'($urandom_range(0, 1));
            w.empty_name  = 1'b1;
            name_words.push_back(w);
            n++;
        end
        if (counted)
            random_words += n;
        name_buf.delete();
    endtask

    function automatic int unsigned pick_code_point();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 9))
                    0:       return 'h80;
                    1:       return 'h7FF;
                    2:       return 'h800;
                    3:       return 'hD7FF;
                    4:       return 'hE000;
                    5:       return 'hFFFF;
                    6:       return 'h10000;
                    7:       return 'h10FFFF;
                    8:       return 'h7E;
                    default: return 'h100000;
                endcase
            1, 2, 3: return $urandom_range('h20, 'h7E);
            4, 5:    return $urandom_range('h80, 'h7FF);
            6:       return $urandom_range('h800, 'hD7FF);
            7:       return $urandom_range('hE000, 'hFFFF);
            8:       return $urandom_range('h10000, 'h10FFFF);
            default: return $urandom_range('h100000, 'h10FFFF);
        endcase
    endfunction

    task automatic append_code_point(logic [31:0] cp);
        if (cp < 'h80)
            name_buf.push_back(cp[7:0]);
        else if (cp < 'h800)
        begin
            name_buf.push_back({3'b110, cp[10:6]});
            name_buf.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 'h10000)
        begin
            name_buf.push_back({4'b1110, cp[15:12]});
            name_buf.push_back({2'b10, cp[11:6]});
            name_buf.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            name_buf.push_back({5'b11110, cp[20:18]});
            name_buf.push_back({2'b10, cp[17:12]});
            name_buf.push_back({2'b10, cp[11:6]});
            name_buf.push_back({2'b10, cp[5:0]});
        end
    endtask

    task automatic build_utf8(int unsigned points);
        repeat (points)
            append_code_point(pick_code_point());
    endtask

    task automatic build_ascii(int unsigned len);
        repeat (len)
            name_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    task automatic build_prefix(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            name_buf.push_back(RESERVED_PREFIX[8 * (onv_pkg::PREFIX_LEN - 1 - i) +: 8]);
    endtask

    // One random name; most are well-formed with random content
    task automatic queue_random_name();
        int unsigned pos;
        bit          cut;
        cut = 1'b0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 17, 18:
                build_utf8($urandom_range(1, 8));
            6, 7:
                build_ascii($urandom_range(1, 16));
            8, 9:
            begin
                // well-formed, then one byte overwritten or the tail cut off
                build_utf8($urandom_range(1, 6));
                if ($urandom_range(0, 1) && name_buf.size() > 1)
                    void'(name_buf.pop_back());
                else
                begin
                    pos = $urandom_range(0, name_buf.size() - 1);
                    name_buf[pos] = 8'($urandom_range(0, 255));
                end
            end
            10:
                repeat ($urandom_range(1, 6))
                    name_buf.push_back(8'($urandom_range(0, 255)));
            11:
            begin
                repeat ($urandom_range(1, 3))
                    name_buf.push_back(DOT);
                if ($urandom_range(0, 2) == 0)
                    build_utf8($urandom_range(1, 2));
            end
            12, 13:
                case ($urandom_range(0, 2))
                    0:
                    begin
                        build_prefix(onv_pkg::PREFIX_LEN);
                        build_ascii($urandom_range(0, 4));
                    end
                    1:
                    begin
                        build_prefix($urandom_range(1, onv_pkg::PREFIX_LEN - 1));
                        build_utf8($urandom_range(0, 3));
                        if (name_buf.size() == 0)
                            build_ascii(1);
                    end
                    default:
                    begin
                        build_prefix(onv_pkg::PREFIX_LEN);
                        pos = $urandom_range(0, onv_pkg::PREFIX_LEN - 1);
                        name_buf[pos] = 8'($urandom_range(8'h20, 8'h7E));
                    end
                endcase
            14:
            begin
                // control byte somewhere in a printable name
                build_ascii($urandom_range(1, 10));
                pos = $urandom_range(0, name_buf.size() - 1);
                name_buf[pos] = ($urandom_range(0, 32) == 32) ? 8'h7F
                                                               : 8'($urandom_range(0, 31));
            end
            15:
                ;   // empty name
            default:
            begin
                build_utf8($urandom_range(1, 4));
                cut = 1'b1;
            end
        endcase
        queue_name(cut, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps; hold a word until taken
    // ------------------------------------------------------------------
    name_word_t  offered_word;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive
        logic accepted;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            s_axis_tuser  <= 1'b0;
            clear_name_state();
        end
        else
        begin
            accepted = s_axis_tvalid && s_axis_tready;
            if (accepted)
                predict_verdict(offered_word);
            if (s_axis_tvalid && !accepted)
                ;   // hold the word on offer
            else if (gap_left != 0 || name_words.size() == 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                offered_word = name_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= offered_word.name_byte;
                s_axis_tlast  <= offered_word.end_of_name;
                s_axis_tuser  <= offered_word.empty_name;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: the stall mode is drawn anew now and then; at times ready is
    // held low long enough that the block fills and stalls its input
    // ------------------------------------------------------------------
    int unsigned rx_cycles  = 0;
    int unsigned hold_left  = 0;
    int unsigned stall_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin : receive
        logic ready_next;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            rx_cycles++;
            if (rx_cycles % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_left == 0 && (rx_cycles == 400 || $urandom_range(0, 2999) == 0))
                hold_left = $urandom_range(150, 400);
            if (hold_left != 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
                case (stall_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = 1'($urandom_range(0, 1));
                    2:       ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = (rx_cycles % 8 != 0);
                endcase
            m_axis_tready <= ready_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each verdict word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic [7:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict word, expected none, got %h",
                         $time, m_axis_tdata);
                fault_count++;
            end
            else
            begin
                want = {7'b0, pending_verdicts.pop_front()};
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: name_valid mismatch, expected %h, got %h",
                             $time, want, m_axis_tdata);
                    fault_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned long_done;
        long_done = 0;

        // Directed names: empty, dot forms, byte extremes, UTF-8 corners
        queue_name(1'b0, 1'b0);
        name_buf = '{DOT};                         queue_name(1'b0, 1'b0);
        name_buf = '{DOT, DOT};                    queue_name(1'b0, 1'b0);
        name_buf = '{8'h00};                       queue_name(1'b0, 1'b0);
        name_buf = '{8'hFF};                       queue_name(1'b0, 1'b0);
        name_buf = '{8'hC2, 8'h80};                queue_name(1'b0, 1'b0);
        name_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};  queue_name(1'b0, 1'b0);
        name_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};  queue_name(1'b0, 1'b0);
        name_buf = '{8'hED, 8'hA0, 8'h80};         queue_name(1'b0, 1'b0);
        name_buf = '{8'hE0, 8'h9F, 8'hBF};         queue_name(1'b0, 1'b0);
        name_buf = '{8'hC1};                       queue_name(1'b0, 1'b0);
        name_buf = '{8'h80};                       queue_name(1'b0, 1'b0);
        name_buf = '{8'hE1, 8'h80};                queue_name(1'b0, 1'b0);
        name_buf = '{8'h61};                       queue_name(1'b1, 1'b0);

        // Random names, with a few long ones near the length limit and past it
        while (random_words < RANDOM_WORDS)
        begin
            if (long_done < 3 && $urandom_range(0, 99) == 0)
            begin
                build_ascii(long_done == 0 ? NAME_LIMIT :
                            long_done == 1 ? NAME_LIMIT + 1 : NAME_LIMIT + 80);
                queue_name(1'b0, 1'b0);
                long_done++;
            end
            else
                queue_random_name();
        end
        while (long_done < 3)
        begin
            build_ascii(NAME_LIMIT - 1 + long_done);
            queue_name(1'b0, 1'b0);
            long_done++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every word taken and every verdict seen
        do
            @(negedge clk);
        while (name_words.size() != 0 || s_axis_tvalid || pending_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("object_name_validator test passed");
        else
            $display("object_name_validator test failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("object_name_validator test failed");
        $finish;
    end

endmodule
